FILE: rtl/psr_pkg.sv
// Package for the pub/sub message rings: default sizes, opcodes and item types.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package psr_pkg;

  localparam int unsigned PSR_QUEUE_DEPTH   = 16;
  localparam int unsigned PSR_NUM_QUEUES    = 4;
  localparam int unsigned PSR_NUM_TASKS     = 16;
  localparam int unsigned PSR_NUM_SYS_FUNCS = 16;

  localparam logic [2:0] OP_CLEAR       = 3'd0;
  localparam logic [2:0] OP_SUBSCRIBE   = 3'd1;
  localparam logic [2:0] OP_UNSUBSCRIBE = 3'd2;
  localparam logic [2:0] OP_PUBLISH     = 3'd3;
  localparam logic [2:0] OP_READ        = 3'd4;

  localparam logic KIND_TASK = 1'b0;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  queue_id;
    logic        participant_kind;
    logic [3:0]  participant_index;
    logic [7:0]  entry_size_in;
    logic [7:0]  entry_type_in;
    logic [31:0] entry_data_in;
  } psr_in_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  read_size;
    logic [7:0]  read_type;
    logic [31:0] read_data;
    logic [5:0]  subscriber_total;
  } psr_out_t;

  typedef struct packed {
    logic [7:0]  size;
    logic [7:0]  kind;
    logic [31:0] data;
  } psr_entry_t;

endpackage

FILE: rtl/pubsub_ring_with_unread_counters.sv
// Top level of the pub/sub message rings with per-participant unread counters.
// Depends on psr_pkg and psr_mem.
`timescale 1ns / 1ps

// One item at a time. Clear, subscribe, unsubscribe and refused items pass through
// ST_LOOK and ST_FIN before out_valid rises. A read that finds nothing unread also
// passes ST_RCNT, and a read that returns an entry passes ST_RCNT and ST_RDAT.
// A publish walks over all participants of the queue in ST_SWEEP through the read port
// of the unread-count memory, one participant a cycle, with one shared add/subtract
// unit. The next item can be taken while the last result is still held by out_stall;
// its own result then waits in ST_FIN. Ring entries are never cleared; subscription
// marks are flip-flops cleared by reset, so no clearing pass is needed after reset.
module pubsub_ring_with_unread_counters #(
  parameter int unsigned QUEUE_DEPTH   = psr_pkg::PSR_QUEUE_DEPTH,
  parameter int unsigned NUM_QUEUES    = psr_pkg::PSR_NUM_QUEUES,
  parameter int unsigned NUM_TASKS     = psr_pkg::PSR_NUM_TASKS,
  parameter int unsigned NUM_SYS_FUNCS = psr_pkg::PSR_NUM_SYS_FUNCS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psr_pkg::psr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output psr_pkg::psr_out_t out_data
);

  import psr_pkg::*;

  localparam int unsigned PARTS   = NUM_TASKS + NUM_SYS_FUNCS;
  localparam int unsigned NSLOT   = NUM_QUEUES * PARTS;
  localparam int unsigned SLOT_W  = $clog2(NSLOT);
  localparam int unsigned NENT    = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned ENT_W   = $clog2(NENT);
  localparam int unsigned QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SC_W    = $clog2(PARTS + 1);
  localparam int unsigned MAX_A   = (CNT_W > SC_W) ? CNT_W : SC_W;
  localparam int unsigned MAX_B   = (MAX_A > PTR_W) ? MAX_A : PTR_W;
  localparam int unsigned AL_W    = MAX_B + 1;
  localparam int unsigned ENTRY_W = $bits(psr_entry_t);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_RCNT  = 3'd2;
  localparam logic [2:0] ST_RDAT  = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  psr_in_t          req_r, req_nxt;
  psr_out_t         res_r, res_nxt;
  psr_out_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PTR_W-1:0] wp_r [NUM_QUEUES];
  logic [PTR_W-1:0] wp_nxt [NUM_QUEUES];
  logic [SC_W-1:0]  sc_r [NUM_QUEUES];
  logic [SC_W-1:0]  sc_nxt [NUM_QUEUES];
  logic [NSLOT-1:0] mark_r, mark_nxt;
  logic [SC_W-1:0]  sw_idx_r, sw_idx_nxt;
  logic             wb_vld_r, wb_vld_nxt;
  logic [SLOT_W-1:0] wb_slot_r, wb_slot_nxt;

  logic              cnt_we, cnt_re;
  logic [SLOT_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic              ent_we, ent_re;
  logic [ENT_W-1:0]  ent_waddr, ent_raddr;
  psr_entry_t        ent_wdata, ent_rdata;

  logic [AL_W-1:0]   alu_a, alu_b, alu_res, pos_full;
  logic              alu_sub;

  logic              q_ok, known, mark_cur;
  logic [QW-1:0]     q_idx;
  logic [SLOT_W-1:0] slot, slot_base, sw_slot;
  logic [ENT_W-1:0]  ent_base;
  logic [NSLOT-1:0]  row_hit;
  logic [15:0]       sc_ext;

  psr_mem #(.WIDTH(CNT_W), .DEPTH(NSLOT)) u_cnt_mem (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_en   (cnt_re),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rdata)
  );

  psr_mem #(.WIDTH(ENTRY_W), .DEPTH(NENT)) u_ent_mem (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (ent_waddr),
    .wr_data (ent_wdata),
    .rd_en   (ent_re),
    .rd_addr (ent_raddr),
    .rd_data (ent_rdata)
  );

  for (genvar s = 0; s < NSLOT; s++) begin : g_row
    localparam int unsigned SQ = s / PARTS;
    assign row_hit[s] = (q_idx == QW'(SQ));
  end

  // shared add/subtract unit
  assign alu_res  = alu_a + (alu_sub ? ~alu_b : alu_b) + AL_W'(alu_sub);
  assign pos_full = alu_res[AL_W-1] ? alu_res + AL_W'(QUEUE_DEPTH) : alu_res;

  assign q_idx     = QW'(req_r.queue_id);
  assign q_ok      = (32'(req_r.queue_id) < NUM_QUEUES);
  assign known     = req_r.participant_kind ? (32'(req_r.participant_index) < NUM_SYS_FUNCS)
                                            : (32'(req_r.participant_index) < NUM_TASKS);
  assign slot_base = SLOT_W'(32'(q_idx) * PARTS);
  assign slot      = SLOT_W'(32'(slot_base) + (req_r.participant_kind
                       ? NUM_TASKS + 32'(req_r.participant_index)
                       : 32'(req_r.participant_index)));
  assign sw_slot   = SLOT_W'(32'(slot_base) + 32'(sw_idx_r));
  assign ent_base  = ENT_W'(32'(q_idx) * QUEUE_DEPTH);
  assign mark_cur  = (known && q_ok) ? mark_r[slot] : 1'b0;
  assign sc_ext    = 16'(sc_r[q_idx]);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    wp_nxt        = wp_r;
    sc_nxt        = sc_r;
    mark_nxt      = mark_r;
    sw_idx_nxt    = sw_idx_r;
    wb_vld_nxt    = 1'b0;
    wb_slot_nxt   = wb_slot_r;
    cnt_we        = 1'b0;
    cnt_waddr     = slot;
    cnt_wdata     = '0;
    cnt_re        = 1'b0;
    cnt_raddr     = slot;
    ent_we        = 1'b0;
    ent_waddr     = ent_base + ENT_W'(wp_r[q_idx]);
    ent_wdata     = '{size: req_r.entry_size_in, kind: req_r.entry_type_in,
                      data: req_r.entry_data_in};
    ent_re        = 1'b0;
    ent_raddr     = ent_base + ENT_W'(PTR_W'(pos_full));
    alu_a         = AL_W'(sc_r[q_idx]);
    alu_b         = AL_W'(1);
    alu_sub       = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        res_nxt        = '0;
        res_nxt.status = 1'b1;
        state_nxt      = ST_FIN;
        if (q_ok) begin
          unique case (req_r.opcode)
            OP_CLEAR: begin
              mark_nxt       = mark_r & ~row_hit;
              wp_nxt[q_idx]  = '0;
              sc_nxt[q_idx]  = '0;
              res_nxt.status = 1'b0;
            end
            OP_SUBSCRIBE: begin
              if (known) begin
                res_nxt.status = 1'b0;
                if (!mark_cur) begin
                  mark_nxt[slot] = 1'b1;
                  cnt_we         = 1'b1;
                  sc_nxt[q_idx]  = SC_W'(alu_res);
                end else if (req_r.participant_kind != KIND_TASK) begin
                  cnt_we = 1'b1;
                end
              end
            end
            OP_UNSUBSCRIBE: begin
              if (mark_cur) begin
                mark_nxt[slot] = 1'b0;
                alu_sub        = 1'b1;
                sc_nxt[q_idx]  = SC_W'(alu_res);
                res_nxt.status = 1'b0;
              end
            end
            OP_PUBLISH: begin
              ent_we         = 1'b1;
              alu_a          = AL_W'(wp_r[q_idx]);
              wp_nxt[q_idx]  = (alu_res == AL_W'(QUEUE_DEPTH)) ? '0 : PTR_W'(alu_res);
              sw_idx_nxt     = '0;
              res_nxt.status = 1'b0;
              state_nxt      = ST_SWEEP;
            end
            OP_READ: begin
              if (mark_cur) begin
                cnt_re    = 1'b1;
                state_nxt = ST_RCNT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RCNT: begin
        if (cnt_rdata == '0) begin
          state_nxt = ST_FIN;
        end else begin
          alu_a     = AL_W'(wp_r[q_idx]);
          alu_b     = AL_W'(cnt_rdata);
          alu_sub   = 1'b1;
          ent_re    = 1'b1;
          state_nxt = ST_RDAT;
        end
      end
      ST_RDAT: begin
        res_nxt.status    = 1'b0;
        res_nxt.read_size = ent_rdata.size;
        res_nxt.read_type = ent_rdata.kind;
        res_nxt.read_data = ent_rdata.data;
        alu_a             = AL_W'(cnt_rdata);
        alu_sub           = 1'b1;
        cnt_we            = 1'b1;
        cnt_wdata         = CNT_W'(alu_res);
        state_nxt         = ST_FIN;
      end
      ST_SWEEP: begin
        // read of participant n overlaps the write-back of participant n-1
        if (32'(sw_idx_r) < PARTS) begin
          cnt_re      = 1'b1;
          cnt_raddr   = sw_slot;
          wb_vld_nxt  = 1'b1;
          wb_slot_nxt = sw_slot;
          sw_idx_nxt  = sw_idx_r + SC_W'(1);
        end
        if (wb_vld_r && mark_r[wb_slot_r] && (cnt_rdata < CNT_W'(QUEUE_DEPTH))) begin
          alu_a     = AL_W'(cnt_rdata);
          cnt_we    = 1'b1;
          cnt_waddr = wb_slot_r;
          cnt_wdata = CNT_W'(alu_res);
        end
        if ((32'(sw_idx_r) >= PARTS) && !wb_vld_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt                  = res_r;
          out_nxt.subscriber_total = q_ok ? sc_ext[5:0] : 6'd0;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mark_r      <= '0;
      wb_vld_r    <= 1'b0;
      sw_idx_r    <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        wp_r[i] <= '0;
        sc_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mark_r      <= mark_nxt;
      wb_vld_r    <= wb_vld_nxt;
      sw_idx_r    <= sw_idx_nxt;
      wp_r        <= wp_nxt;
      sc_r        <= sc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    wb_slot_r <= wb_slot_nxt;
  end

`ifndef SYNTHESIS
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (32'(sw_idx_r) <= PARTS))
    else $error("participant walk ran past the end of the queue");

  a_wb_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    wb_vld_r |-> (state_r == ST_SWEEP))
    else $error("count write-back pending outside the publish walk");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RCNT && cnt_rdata != '0) |=> (state_r == ST_RDAT))
    else $error("nonzero unread count did not lead to an entry read");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("finished item was not handed to the output register");
`endif

endmodule

FILE: rtl/psr_mem.sv
// Simple dual-port memory: one write port, one read port with registered data.
// No dependencies; used for the ring entries and the unread counts.
`timescale 1ns / 1ps

module psr_mem #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: tb/tb_pubsub_ring_with_unread_counters.sv
// Testbench for pubsub_ring_with_unread_counters: directed and random ring traffic,
// each result checked against an in-bench model of the rings. Depends on psr_pkg.
`timescale 1ns / 1ps

module tb_pubsub_ring_with_unread_counters;
  import psr_pkg::*;

  localparam int unsigned PARTS = PSR_NUM_TASKS + PSR_NUM_SYS_FUNCS;
  localparam logic KIND_SYS = 1'b1;
  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 64;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  psr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  psr_out_t out_data;

  pubsub_ring_with_unread_counters uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ring model state
  bit [7:0]  size_mem [PSR_NUM_QUEUES][PSR_QUEUE_DEPTH];
  bit [7:0]  type_mem [PSR_NUM_QUEUES][PSR_QUEUE_DEPTH];
  bit [31:0] data_mem [PSR_NUM_QUEUES][PSR_QUEUE_DEPTH];
  bit [3:0]  wr_ptr [PSR_NUM_QUEUES];
  bit        sub_mark [PSR_NUM_QUEUES][PARTS];
  bit [4:0]  unread [PSR_NUM_QUEUES][PARTS];
  bit [5:0]  sub_total [PSR_NUM_QUEUES];

  psr_out_t pending_results[$];
  psr_out_t want_result;
  int       mismatches = 0;
  int       results_seen = 0;
  int       cycles = 0;
  bit       no_idle = 1'b0;

  function automatic psr_out_t ring_step(input psr_in_t it);
    psr_out_t   res;
    int         q;
    int         s;
    bit         known;
    logic [4:0] cnt;
    logic [3:0] pos;
    res = '0;
    res.status = 1'b1;
    q = int'(it.queue_id);
    if (it.participant_kind == KIND_TASK) begin
      known = it.participant_index < PSR_NUM_TASKS;
      s = int'(it.participant_index);
    end else begin
      known = it.participant_index < PSR_NUM_SYS_FUNCS;
      s = int'(PSR_NUM_TASKS) + int'(it.participant_index);
    end
    case (it.opcode)
      OP_CLEAR: begin
        for (int p = 0; p < PARTS; p++) begin
          sub_mark[q][p] = 1'b0;
          unread[q][p] = '0;
        end
        sub_total[q] = '0;
        wr_ptr[q] = '0;
        res.status = 1'b0;
      end
      OP_SUBSCRIBE: begin
        if (known) begin
          if (!sub_mark[q][s]) begin
            sub_mark[q][s] = 1'b1;
            unread[q][s] = '0;
            sub_total[q] = sub_total[q] + 6'd1;
          end else if (it.participant_kind != KIND_TASK) begin
            unread[q][s] = '0;
          end
          res.status = 1'b0;
        end
      end
      OP_UNSUBSCRIBE: begin
        if (known && sub_mark[q][s]) begin
          sub_mark[q][s] = 1'b0;
          unread[q][s] = '0;
          sub_total[q] = sub_total[q] - 6'd1;
          res.status = 1'b0;
        end
      end
      OP_PUBLISH: begin
        size_mem[q][wr_ptr[q]] = it.entry_size_in;
        type_mem[q][wr_ptr[q]] = it.entry_type_in;
        data_mem[q][wr_ptr[q]] = it.entry_data_in;
        wr_ptr[q] = wr_ptr[q] + 4'd1;
        for (int p = 0; p < PARTS; p++)
          if (sub_mark[q][p] && unread[q][p] < PSR_QUEUE_DEPTH)
            unread[q][p] = unread[q][p] + 5'd1;
        res.status = 1'b0;
      end
      OP_READ: begin
        if (known && sub_mark[q][s] && unread[q][s] != 0) begin
          cnt = unread[q][s];
          pos = wr_ptr[q] - cnt[3:0];
          res.read_size = size_mem[q][pos];
          res.read_type = type_mem[q][pos];
          res.read_data = data_mem[q][pos];
          unread[q][s] = cnt - 5'd1;
          res.status = 1'b0;
        end
      end
      default: ;
    endcase
    res.subscriber_total = sub_total[q];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_results.push_back(ring_step(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want_result = pending_results.pop_front();
        check_field("status", 32'(out_data.status), 32'(want_result.status));
        check_field("read_size", 32'(out_data.read_size), 32'(want_result.read_size));
        check_field("read_type", 32'(out_data.read_type), 32'(want_result.read_type));
        check_field("read_data", out_data.read_data, want_result.read_data);
        check_field("subscriber_total", 32'(out_data.subscriber_total),
                    32'(want_result.subscriber_total));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 34);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic psr_in_t make_item(input logic [2:0] op, input logic [1:0] q,
                                        input logic kind, input logic [3:0] idx,
                                        input logic [7:0] sz, input logic [7:0] ty,
                                        input logic [31:0] dat);
    psr_in_t it;
    it.opcode = op;
    it.queue_id = q;
    it.participant_kind = kind;
    it.participant_index = idx;
    it.entry_size_in = sz;
    it.entry_type_in = ty;
    it.entry_data_in = dat;
    return it;
  endfunction

  task automatic send_item(input psr_in_t it);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  function automatic psr_in_t random_item();
    psr_in_t it;
    int      r;
    it.entry_size_in = 8'($urandom);
    it.entry_type_in = 8'($urandom);
    it.entry_data_in = 32'($urandom);
    it.queue_id = 2'($urandom_range(3));
    it.participant_kind = 1'($urandom_range(1));
    it.participant_index = 4'(($urandom_range(99) < 80) ? $urandom_range(3)
                                                        : $urandom_range(15));
    r = $urandom_range(99);
    if (r < 3)       it.opcode = OP_CLEAR;
    else if (r < 15) it.opcode = OP_SUBSCRIBE;
    else if (r < 23) it.opcode = OP_UNSUBSCRIBE;
    else if (r < 55) it.opcode = OP_PUBLISH;
    else if (r < 97) it.opcode = OP_READ;
    else             it.opcode = 3'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
    return it;
  endfunction

  task automatic test_directed();
    send_item(make_item(OP_CLEAR, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_READ, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_UNSUBSCRIBE, 2'd0, KIND_SYS, 4'd15, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_PUBLISH, 2'd0, KIND_TASK, 4'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(OP_SUBSCRIBE, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_SUBSCRIBE, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_SUBSCRIBE, 2'd0, KIND_SYS, 4'd15, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_PUBLISH, 2'd0, KIND_SYS, 4'd15, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(OP_PUBLISH, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_PUBLISH, 2'd0, KIND_TASK, 4'd0, 8'hA5, 8'h5A, 32'hA5A5_5A5A));
    send_item(make_item(OP_READ, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_READ, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_READ, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_READ, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_READ, 2'd0, KIND_SYS, 4'd15, 8'h00, 8'h00, 32'h0));
    // system function resubscribe drops its backlog
    send_item(make_item(OP_SUBSCRIBE, 2'd0, KIND_SYS, 4'd15, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_READ, 2'd0, KIND_SYS, 4'd15, 8'h00, 8'h00, 32'h0));
    for (logic [3:0] op = OP_UNDEF_LO; op <= OP_UNDEF_HI; op++)
      send_item(make_item(op[2:0], 2'd0, KIND_SYS, 4'd15, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(OP_UNSUBSCRIBE, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_READ, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_SUBSCRIBE, 2'd3, KIND_TASK, 4'd15, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_CLEAR, 2'd0, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
  endtask

  task automatic test_saturation();
    send_item(make_item(OP_SUBSCRIBE, 2'd1, KIND_TASK, 4'd3, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_SUBSCRIBE, 2'd1, KIND_SYS, 4'd0, 8'h00, 8'h00, 32'h0));
    repeat (PSR_QUEUE_DEPTH + 2)
      send_item(make_item(OP_PUBLISH, 2'd1, KIND_TASK, 4'd0, 8'($urandom), 8'($urandom),
                          32'($urandom)));
    repeat (PSR_QUEUE_DEPTH + 1)
      send_item(make_item(OP_READ, 2'd1, KIND_TASK, 4'd3, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_UNSUBSCRIBE, 2'd1, KIND_SYS, 4'd0, 8'h00, 8'h00, 32'h0));
    send_item(make_item(OP_CLEAR, 2'd1, KIND_TASK, 4'd0, 8'h00, 8'h00, 32'h0));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count)
      send_item(random_item());
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count)
      send_item(random_item());
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random_traffic(1050);
    test_back_to_back(350);
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
